// ----- rtl/ssg_pkg.sv -----
// Shared types and constants for the stratified sample generator.
// No dependencies; used by ssg_ctrl, ssg_dp and stratified_sample_generator.
package ssg_pkg;

    // Request type codes
    localparam logic REQ_SEED = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    // Output coordinate width
    localparam int OUT_W = 24;

    // Park-Miller constants
    localparam logic [15:0] LCG_MULT = 16'd48271;
    localparam logic [31:0] LCG_MOD  = 32'h7fff_ffff;

    // Warm-up draws after seeding, minus one
    localparam logic [3:0] WARM_LAST = 4'd3;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0_0000_0000_0001,
        ST_LCG_MUL   = 13'b0_0000_0000_0010,
        ST_LCG_FOLD  = 13'b0_0000_0000_0100,
        ST_WARM      = 13'b0_0000_0000_1000,
        ST_DECIDE    = 13'b0_0000_0001_0000,
        ST_DRAW_CELL = 13'b0_0000_0010_0000,
        ST_PROBE     = 13'b0_0000_0100_0000,
        ST_FIRST_X   = 13'b0_0000_1000_0000,
        ST_FIRST_Y   = 13'b0_0001_0000_0000,
        ST_JIT_X     = 13'b0_0010_0000_0000,
        ST_JIT_Y     = 13'b0_0100_0000_0000,
        ST_MARK      = 13'b0_1000_0000_0000,
        ST_FAIL      = 13'b1_0000_0000_0000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic seed_init;
        logic lcg_mul;
        logic lcg_fold;
        logic warm_load;
        logic cnt_dec;
        logic gen_step;
        logic ld_cell;
        logic probe_next;
        logic row_next;
        logic ld_sx;
        logic ld_sy;
        logic jitter;
        logic mark;
        logic emit_full;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic set_full;
        logic set_empty;
        logic too_wide;
        logic row_hit;
        logic row_last;
        logic tries_last;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/ssg_ctrl.sv -----
// Controller state machine of the stratified sample generator.
// Depends on ssg_pkg; drives ssg_dp through ssg_pkg::cmd_t.
module ssg_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             req_type,
    output logic             in_stall,
    input  ssg_pkg::status_t status,
    output ssg_pkg::cmd_t    cmd
);

    ssg_pkg::state_t state_reg;
    ssg_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ssg_pkg::ST_IDLE);

    // Sequence the seed and draw steps
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ssg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == ssg_pkg::REQ_DRAW)
                    begin
                        state_next = ssg_pkg::ST_DECIDE;
                    end
                    else
                    begin
                        cmd.seed_init = 1'b1;
                        state_next    = ssg_pkg::ST_LCG_MUL;
                    end
                end
            end
            ssg_pkg::ST_LCG_MUL:
            begin
                cmd.lcg_mul = 1'b1;
                state_next  = ssg_pkg::ST_LCG_FOLD;
            end
            ssg_pkg::ST_LCG_FOLD:
            begin
                cmd.lcg_fold = 1'b1;
                if (status.cnt_zero)
                begin
                    cmd.warm_load = 1'b1;
                    state_next    = ssg_pkg::ST_WARM;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ssg_pkg::ST_LCG_MUL;
                end
            end
            ssg_pkg::ST_WARM:
            begin
                cmd.gen_step = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = ssg_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                end
            end
            ssg_pkg::ST_DECIDE:
            begin
                if (status.set_full)
                begin
                    state_next = ssg_pkg::ST_FAIL;
                end
                else if (status.set_empty)
                begin
                    state_next = ssg_pkg::ST_FIRST_X;
                end
                else
                begin
                    state_next = ssg_pkg::ST_DRAW_CELL;
                end
            end
            ssg_pkg::ST_DRAW_CELL:
            begin
                cmd.gen_step = 1'b1;
                cmd.ld_cell  = 1'b1;
                state_next   = status.too_wide ? ssg_pkg::ST_FAIL : ssg_pkg::ST_PROBE;
            end
            ssg_pkg::ST_PROBE:
            begin
                if (status.row_hit)
                begin
                    if (status.tries_last)
                    begin
                        state_next = ssg_pkg::ST_FAIL;
                    end
                    else
                    begin
                        cmd.probe_next = 1'b1;
                    end
                end
                else if (status.row_last)
                begin
                    state_next = ssg_pkg::ST_JIT_X;
                end
                else
                begin
                    cmd.row_next = 1'b1;
                end
            end
            ssg_pkg::ST_FIRST_X:
            begin
                cmd.gen_step = 1'b1;
                cmd.ld_sx    = 1'b1;
                state_next   = ssg_pkg::ST_FIRST_Y;
            end
            ssg_pkg::ST_FIRST_Y:
            begin
                cmd.gen_step = 1'b1;
                cmd.ld_sy    = 1'b1;
                state_next   = ssg_pkg::ST_MARK;
            end
            ssg_pkg::ST_JIT_X:
            begin
                cmd.gen_step = 1'b1;
                cmd.ld_sx    = 1'b1;
                cmd.jitter   = 1'b1;
                state_next   = ssg_pkg::ST_JIT_Y;
            end
            ssg_pkg::ST_JIT_Y:
            begin
                cmd.gen_step = 1'b1;
                cmd.ld_sy    = 1'b1;
                cmd.jitter   = 1'b1;
                state_next   = ssg_pkg::ST_MARK;
            end
            ssg_pkg::ST_MARK:
            begin
                if (status.out_free)
                begin
                    cmd.mark   = 1'b1;
                    state_next = ssg_pkg::ST_IDLE;
                end
            end
            ssg_pkg::ST_FAIL:
            begin
                if (status.out_free)
                begin
                    cmd.emit_full = 1'b1;
                    state_next    = ssg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssg_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // An accepted request always starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != ssg_pkg::ST_IDLE))
        else $error("accepted request left controller idle");

    // A result is produced only from the mark or fail step
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mark || cmd.emit_full) |->
            (state_reg == ssg_pkg::ST_MARK || state_reg == ssg_pkg::ST_FAIL))
        else $error("result issued outside mark or fail step");

    // An LCG fold never overlaps a generator advance
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lcg_fold |-> !cmd.gen_step)
        else $error("generator words written twice in one cycle");
`endif

endmodule

// ----- rtl/ssg_dp.sv -----
// Datapath of the stratified sample generator: generator, seeding LCG,
// stratum map, probe counters and output register. Depends on ssg_pkg.
module ssg_dp
#(
    parameter int GRID_SIDE     = 32,
    parameter int FRACTION_BITS = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ssg_pkg::cmd_t               cmd,
    output ssg_pkg::status_t            status,
    input  logic [15:0]                 pixel_x,
    input  logic [15:0]                 pixel_y,
    input  logic [3:0]                  dimension_index,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [ssg_pkg::OUT_W-1:0]   sample_x,
    output logic [ssg_pkg::OUT_W-1:0]   sample_y,
    output logic                        set_full
);

    localparam int FB      = FRACTION_BITS;
    localparam int LG      = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int KW      = $clog2(LG + 1);
    localparam int CELL_W  = 2 * LG;
    localparam int SW      = LG + 1;
    localparam int JW      = FB + LG;
    localparam int GRID_SQ = GRID_SIDE * GRID_SIDE;
    localparam logic [FB-1:0] UNIFORM_CAP =
        FB'(((64'd1 << FB) * 64'd99999) / 64'd100000);

    logic [31:0]           words_reg [4];
    logic [31:0]           lcg_reg;
    logic [47:0]           prod_reg;
    logic [3:0]            cnt_reg;
    logic [GRID_SIDE-1:0]  map_reg [GRID_SIDE];
    logic [10:0]           samples_reg;
    logic [KW-1:0]         k_reg;
    logic [CELL_W-1:0]     cell_reg;
    logic [CELL_W-1:0]     tries_reg;
    logic [LG-1:0]         row_off_reg;
    logic [FB-1:0]         sx_reg;
    logic [FB-1:0]         sy_reg;
    logic                  out_valid_reg;
    logic [ssg_pkg::OUT_W-1:0] out_sx_reg;
    logic [ssg_pkg::OUT_W-1:0] out_sy_reg;
    logic                  out_full_reg;

    // Generator output and next words
    logic [31:0] gen_out;
    logic [31:0] gw0, gw1, gw2, gw3, gt;
    logic [FB-1:0] u_raw;
    logic [FB-1:0] u_val;

    always_comb
    begin
        gen_out = words_reg[0] + words_reg[3];
        gt  = words_reg[1] << 9;
        gw2 = words_reg[2] ^ words_reg[0];
        gw3 = words_reg[3] ^ words_reg[1];
        gw1 = words_reg[1] ^ gw2;
        gw0 = words_reg[0] ^ gw3;
        gw2 = gw2 ^ gt;
        gw3 = {gw3[20:0], gw3[31:21]};
        u_raw = gen_out[31 -: FB];
        u_val = (u_raw > UNIFORM_CAP) ? UNIFORM_CAP : u_raw;
    end

    // Park-Miller fold modulo 2^31-1
    logic [31:0] fold_sum;
    logic [31:0] lcg_new;

    always_comb
    begin
        fold_sum = {1'b0, prod_reg[30:0]} + 32'(prod_reg[47:31]);
        lcg_new  = (fold_sum >= ssg_pkg::LCG_MOD) ? (fold_sum - ssg_pkg::LCG_MOD) : fold_sum;
    end

    // Grid level from the sample count
    logic [KW-1:0] k_calc;
    logic          too_wide;

    always_comb
    begin
        k_calc = KW'(1);
        for (int j = 1; j < LG; j++)
        begin
            if (samples_reg >= (11'd1 << (2 * j)))
            begin
                k_calc = k_calc + KW'(1);
            end
        end
        too_wide = (32'd1 << k_calc) > 32'(GRID_SIDE);
    end

    // Probe geometry of the current cell
    logic [CELL_W-1:0]  wmask;
    logic [CELL_W-1:0]  cmask;
    logic [SW-1:0]      side;
    logic [CELL_W-1:0]  col_cell;
    logic [CELL_W-1:0]  row_cell;
    logic [SW-1:0]      row0;
    logic [SW-1:0]      col0;
    logic [LG-1:0]      row_idx;
    logic [GRID_SIDE-1:0] col_mask;
    logic [CELL_W-1:0]  cell_draw;

    always_comb
    begin
        wmask    = CELL_W'((32'd1 << k_reg) - 32'd1);
        cmask    = CELL_W'((64'd1 << (2 * k_reg)) - 64'd1);
        side     = SW'(GRID_SIDE >> k_reg);
        col_cell = cell_reg & wmask;
        row_cell = cell_reg >> k_reg;
        row0     = SW'(32'(row_cell) * 32'(side));
        col0     = SW'(32'(col_cell) * 32'(side));
        row_idx  = LG'(row0 + SW'(row_off_reg));
        col_mask = GRID_SIDE'(((64'd1 << side) - 64'd1) << col0);
        cell_draw = CELL_W'(u_val >> (FB - 2 * int'(k_calc)));
    end

    // Jittered coordinate inside the cell
    logic [FB-1:0] jit_x;
    logic [FB-1:0] jit_y;

    always_comb
    begin
        jit_x = FB'(((JW'(col_cell) << FB) + JW'(u_val)) >> k_reg);
        jit_y = FB'(((JW'(row_cell) << FB) + JW'(u_val)) >> k_reg);
    end

    // Stratum of the finished sample
    logic [LG-1:0] cx;
    logic [LG-1:0] cy;

    always_comb
    begin
        cx = LG'(((FB + SW)'(sx_reg) * (FB + SW)'(GRID_SIDE)) >> FB);
        cy = LG'(((FB + SW)'(sy_reg) * (FB + SW)'(GRID_SIDE)) >> FB);
    end

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    // Generator words: seed load, LCG mix, advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else if (cmd.seed_init)
        begin
            words_reg[0] <= '0;
            words_reg[1] <= 32'(dimension_index);
            words_reg[2] <= 32'(pixel_x);
            words_reg[3] <= 32'(pixel_y);
        end
        else if (cmd.lcg_fold)
        begin
            words_reg[cnt_reg[1:0]] <= words_reg[cnt_reg[1:0]] ^ lcg_new;
        end
        else if (cmd.gen_step)
        begin
            words_reg[0] <= gw0;
            words_reg[1] <= gw1;
            words_reg[2] <= gw2;
            words_reg[3] <= gw3;
        end
    end

    // LCG value and product
    always_ff @(posedge clk)
    begin
        if (cmd.seed_init)
        begin
            lcg_reg <= {pixel_x, 16'd0} ^ (32'(pixel_y) + 32'd1);
        end
        else if (cmd.lcg_fold)
        begin
            lcg_reg <= lcg_new;
        end
        if (cmd.lcg_mul)
        begin
            prod_reg <= 48'(lcg_reg) * 48'(ssg_pkg::LCG_MULT);
        end
    end

    // Step counter for LCG and warm-up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.seed_init)
        begin
            cnt_reg <= dimension_index;
        end
        else if (cmd.warm_load)
        begin
            cnt_reg <= ssg_pkg::WARM_LAST;
        end
        else if (cmd.cnt_dec)
        begin
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    // Stratum map and sample count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GRID_SIDE; i++)
            begin
                map_reg[i] <= '0;
            end
            samples_reg <= '0;
        end
        else if (cmd.seed_init)
        begin
            for (int i = 0; i < GRID_SIDE; i++)
            begin
                map_reg[i] <= '0;
            end
            samples_reg <= '0;
        end
        else if (cmd.mark)
        begin
            map_reg[cy] <= map_reg[cy] | (GRID_SIDE'(1) << cx);
            samples_reg <= samples_reg + 11'd1;
        end
    end

    // Probe counters and sample coordinates
    always_ff @(posedge clk)
    begin
        if (cmd.ld_cell)
        begin
            k_reg       <= k_calc;
            cell_reg    <= cell_draw;
            tries_reg   <= '0;
            row_off_reg <= '0;
        end
        else if (cmd.probe_next)
        begin
            cell_reg    <= (cell_reg + CELL_W'(1)) & cmask;
            tries_reg   <= tries_reg + CELL_W'(1);
            row_off_reg <= '0;
        end
        else if (cmd.row_next)
        begin
            row_off_reg <= row_off_reg + LG'(1);
        end
        if (cmd.ld_sx)
        begin
            sx_reg <= cmd.jitter ? jit_x : u_val;
        end
        if (cmd.ld_sy)
        begin
            sy_reg <= cmd.jitter ? jit_y : u_val;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.mark || cmd.emit_full)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark)
        begin
            out_sx_reg   <= ssg_pkg::OUT_W'(sx_reg);
            out_sy_reg   <= ssg_pkg::OUT_W'(sy_reg);
            out_full_reg <= 1'b0;
        end
        else if (cmd.emit_full)
        begin
            out_sx_reg   <= '0;
            out_sy_reg   <= '0;
            out_full_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample_x  = out_sx_reg;
    assign sample_y  = out_sy_reg;
    assign set_full  = out_full_reg;

    // Status back to the controller
    always_comb
    begin
        status.cnt_zero   = (cnt_reg == 4'd0);
        status.set_full   = (samples_reg >= 11'(GRID_SQ));
        status.set_empty  = (samples_reg == 11'd0);
        status.too_wide   = too_wide;
        status.row_hit    = |(map_reg[row_idx] & col_mask);
        status.row_last   = (SW'(row_off_reg) == (side - SW'(1)));
        status.tries_last = (tries_reg == cmask);
        status.out_free   = out_free;
    end

`ifndef SYNTHESIS
    // Sample count never passes the stratum count
    assert property (@(posedge clk) disable iff (!rst_n)
        samples_reg <= 11'(GRID_SQ))
        else $error("sample count exceeds stratum count");

    // A full flag carries zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_full_reg) |-> (out_sx_reg == '0 && out_sy_reg == '0))
        else $error("full result with nonzero coordinates");

    // Marking a sample always bumps the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark |=> (samples_reg == $past(samples_reg) + 11'd1))
        else $error("mark did not advance sample count");
`endif

endmodule

// ----- rtl/stratified_sample_generator.sv -----
// Stratified 2D sample generator: one seed request loads a xoshiro128+
// generator from pixel and dimension and clears the stratum map; each draw
// request returns one 0.24 fixed-point sample or a set-full flag. A seed
// request runs dimension_index+1 LCG steps (a multiply, then a fold) and
// then four warm-up advances. The first draw uses two raw uniform values;
// later draws pick a cell and probe its stratum rows, as the probe reads
// one map row per cycle, so draws late in a set take longer. A full set
// answers with the set-full flag without probing. The block takes one
// request at a time and a result waits in an output register while the
// next request is accepted.
// Depends on ssg_pkg, ssg_ctrl and ssg_dp.
module stratified_sample_generator
#(
    parameter int GRID_SIDE     = 32,
    parameter int FRACTION_BITS = 24
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      req_type,
    input  logic [15:0]               pixel_x,
    input  logic [15:0]               pixel_y,
    input  logic [3:0]                dimension_index,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [ssg_pkg::OUT_W-1:0] sample_x,
    output logic [ssg_pkg::OUT_W-1:0] sample_y,
    output logic                      set_full
);

    ssg_pkg::cmd_t    cmd;
    ssg_pkg::status_t status;

    // Sequence requests
    ssg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Generator, map and output register
    ssg_dp
    #(
        .GRID_SIDE     (GRID_SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .dimension_index (dimension_index),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .sample_x        (sample_x),
        .sample_y        (sample_y),
        .set_full        (set_full)
    );

endmodule

// ----- tb/stratified_sample_generator_checker.sv -----
// Checker for the stratified sample generator: watches the request and result
// channels, predicts each draw result from its own copy of the block state.
// Depends on ssg_pkg.
module stratified_sample_generator_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      req_type,
    input  logic [15:0]               pixel_x,
    input  logic [15:0]               pixel_y,
    input  logic [3:0]                dimension_index,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [ssg_pkg::OUT_W-1:0] sample_x,
    input  logic [ssg_pkg::OUT_W-1:0] sample_y,
    input  logic                      set_full,
    output int                        fail_count,
    output int                        pending_samples,
    output int                        draws_seen,
    output int                        full_seen,
    output logic                      accepted_any
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SIDE     = 32;
    localparam int          FRAC     = 24;
    localparam logic [31:0] CAP      = 32'd16777048;

    typedef struct packed {
        logic [23:0] sx;
        logic [23:0] sy;
        logic        full;
    } sample_t;

    logic [31:0] gen_word [4];
    logic [31:0] strata   [32];
    logic [10:0] taken;
    sample_t     sample_queue [$];

    // Advance the xoshiro128+ generator and return its output
    function automatic logic [31:0] gen_advance();
        logic [31:0] res;
        logic [31:0] t;
        res = gen_word[0] + gen_word[3];
        t = gen_word[1] << 9;
        gen_word[2] ^= gen_word[0];
        gen_word[3] ^= gen_word[1];
        gen_word[1] ^= gen_word[2];
        gen_word[0] ^= gen_word[3];
        gen_word[2] ^= t;
        gen_word[3] = {gen_word[3][20:0], gen_word[3][31:21]};
        return res;
    endfunction

    function automatic logic [31:0] uniform24();
        logic [31:0] v;
        v = gen_advance() >> (32 - FRAC);
        return (v > CAP) ? CAP : v;
    endfunction

    function automatic void mark_stratum(logic [31:0] sx, logic [31:0] sy);
        logic [63:0] cx;
        logic [63:0] cy;
        cx = (64'(sx) * SIDE) >> FRAC;
        cy = (64'(sy) * SIDE) >> FRAC;
        strata[cy[4:0]] |= 32'd1 << cx[4:0];
        taken = taken + 11'd1;
    endfunction

    function automatic bit cell_free(int unsigned width, int unsigned slot);
        int unsigned side;
        int unsigned row0;
        int unsigned col0;
        logic [31:0] mask;
        side = SIDE / width;
        row0 = (slot / width) * side;
        col0 = (slot % width) * side;
        if (side == 0 || side > 32 || col0 + side > 32)
            return 0;
        mask = (32'hFFFF_FFFF >> (32 - side)) << col0;
        for (int unsigned n = row0; n < row0 + side; n++)
            if (n >= 32 || (strata[n] & mask) != 0)
                return 0;
        return 1;
    endfunction

    function automatic void reseed(logic [15:0] x, logic [15:0] y, logic [3:0] dim);
        logic [31:0] lcg;
        lcg = {x, 16'd0} ^ (32'(y) + 32'd1);
        gen_word[0] = '0;
        gen_word[1] = 32'(dim);
        gen_word[2] = 32'(x);
        gen_word[3] = 32'(y);
        for (int i = int'(dim) + 1; i > 0; i--)
        begin
            lcg = 32'((64'(lcg) * 64'(ssg_pkg::LCG_MULT)) % 64'(ssg_pkg::LCG_MOD));
            gen_word[(i - 1) & 3] ^= lcg;
        end
        for (int i = 0; i < 4; i++)
            void'(gen_advance());
        foreach (strata[i])
            strata[i] = '0;
        taken = '0;
    endfunction

    // Predict the result of one draw request
    function automatic sample_t predict_draw();
        sample_t     r;
        logic [31:0] sx;
        logic [31:0] sy;
        int unsigned width;
        int unsigned cells;
        int unsigned slot;
        bit          found;
        logic [63:0] col;
        logic [63:0] row;
        logic [31:0] jx;
        logic [31:0] jy;
        r = '0;
        sx = '0;
        sy = '0;
        found = 0;
        if (taken >= SIDE * SIDE)
        begin
            r.full = 1'b1;
            return r;
        end
        if (taken == 0)
        begin
            sx = uniform24();
            sy = uniform24();
            mark_stratum(sx, sy);
        end
        else
        begin
            width = 2;
            cells = 4;
            while (cells <= taken)
            begin
                width *= 2;
                cells *= 4;
            end
            slot = int'((64'(uniform24()) * cells) >> FRAC);
            if (width <= SIDE)
                for (int unsigned k = 0; k < cells; k++)
                begin
                    if (cell_free(width, slot))
                    begin
                        found = 1;
                        break;
                    end
                    slot = (slot + 1) % cells;
                end
            if (found)
            begin
                col = slot % width;
                row = slot / width;
                jx = uniform24();
                jy = uniform24();
                sx = 32'(((col << FRAC) + jx) / width);
                sy = 32'(((row << FRAC) + jy) / width);
                mark_stratum(sx, sy);
            end
            else
                r.full = 1'b1;
        end
        r.sx = sx[23:0];
        r.sy = sy[23:0];
        return r;
    endfunction

    initial
    begin
        foreach (gen_word[i])
            gen_word[i] = '0;
        foreach (strata[i])
            strata[i] = '0;
        taken = '0;
    end

    assign pending_samples = sample_queue.size();

    // Predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        sample_t want;
        if (!rst_n)
        begin
            fail_count   <= 0;
            draws_seen   <= 0;
            full_seen    <= 0;
            accepted_any <= 1'b0;
        end
        else
        begin
            accepted_any <= (in_valid && !in_stall) || (out_valid && !out_stall);
            if (in_valid && !in_stall)
            begin
                if (req_type == ssg_pkg::REQ_SEED)
                    reseed(pixel_x, pixel_y, dimension_index);
                else
                    sample_queue = {sample_queue, predict_draw()};
            end
            if (out_valid && !out_stall)
            begin
                draws_seen <= draws_seen + 1;
                if (set_full)
                    full_seen <= full_seen + 1;
                if (sample_queue.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = sample_queue.pop_front();
                    if (sample_x !== want.sx || sample_y !== want.sy
                        || set_full !== want.full)
                    begin
                        if (sample_x !== want.sx)
                            $error("sample_x expected %0h got %0h", want.sx, sample_x);
                        if (sample_y !== want.sy)
                            $error("sample_y expected %0h got %0h", want.sy, sample_y);
                        if (set_full !== want.full)
                            $error("set_full expected %0b got %0b", want.full, set_full);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/stratified_sample_generator_tb.sv -----
// Testbench top for the stratified sample generator: drives seed and draw
// requests with random gaps and stalls; depends on ssg_pkg, the block and
// stratified_sample_generator_checker.
module stratified_sample_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      req_type;
    logic [15:0]               pixel_x;
    logic [15:0]               pixel_y;
    logic [3:0]                dimension_index;
    logic                      out_valid;
    logic                      out_stall;
    logic [ssg_pkg::OUT_W-1:0] sample_x;
    logic [ssg_pkg::OUT_W-1:0] sample_y;
    logic                      set_full;
    int                        fail_count;
    int                        pending_samples;
    int                        draws_seen;
    int                        full_seen;
    logic                      accepted_any;
    int                        seeds_sent;
    int                        idle_cycles;

    stratified_sample_generator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .pixel_x(pixel_x), .pixel_y(pixel_y),
        .dimension_index(dimension_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .sample_x(sample_x), .sample_y(sample_y), .set_full(set_full)
    );

    stratified_sample_generator_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .pixel_x(pixel_x), .pixel_y(pixel_y),
        .dimension_index(dimension_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .sample_x(sample_x), .sample_y(sample_y), .set_full(set_full),
        .fail_count(fail_count), .pending_samples(pending_samples),
        .draws_seen(draws_seen), .full_seen(full_seen),
        .accepted_any(accepted_any)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Send one request after a random gap; hold it until accepted
    task automatic send_request(logic kind, logic [15:0] x, logic [15:0] y,
                                logic [3:0] dim);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        req_type        <= kind;
        pixel_x         <= x;
        pixel_y         <= y;
        dimension_index <= dim;
        if (kind == ssg_pkg::REQ_SEED)
            seeds_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic seed_random();
        send_request(ssg_pkg::REQ_SEED, 16'($urandom), 16'($urandom), 4'($urandom));
    endtask

    // Stall the result channel at random, with calm stretches
    initial
    begin
        int wait_n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 9) < 3)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(5, 30)) @(negedge clk);
            end
            wait_n = $urandom_range(0, 6);
            if (wait_n != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(negedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
        end
    end

    // Stop on a long stretch with no handshake
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            #1;
            idle_cycles = accepted_any ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int n_items;
        int burst;
        in_valid        = 1'b0;
        req_type        = ssg_pkg::REQ_SEED;
        pixel_x         = '0;
        pixel_y         = '0;
        dimension_index = '0;
        seeds_sent      = 0;
        rst_n           = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: draws on reset state, field extremes, every dimension edge
        send_request(ssg_pkg::REQ_DRAW, 16'h0000, 16'h0000, 4'h0);
        send_request(ssg_pkg::REQ_DRAW, 16'hFFFF, 16'hFFFF, 4'hF);
        send_request(ssg_pkg::REQ_SEED, 16'h0000, 16'h0000, 4'h0);
        send_request(ssg_pkg::REQ_DRAW, 16'h0000, 16'h0000, 4'h0);
        send_request(ssg_pkg::REQ_SEED, 16'hFFFF, 16'hFFFF, 4'hF);
        for (int i = 0; i < 6; i++)
            send_request(ssg_pkg::REQ_DRAW, '0, '0, '0);
        send_request(ssg_pkg::REQ_SEED, 16'hFFFF, 16'h0000, 4'h7);
        send_request(ssg_pkg::REQ_DRAW, '0, '0, '0);
        send_request(ssg_pkg::REQ_SEED, 16'h0000, 16'hFFFF, 4'h8);
        send_request(ssg_pkg::REQ_DRAW, '0, '0, '0);
        send_request(ssg_pkg::REQ_SEED, 16'h5555, 16'hAAAA, 4'h3);
        send_request(ssg_pkg::REQ_DRAW, '0, '0, '0);

        // Fill one set completely and draw past full
        seed_random();
        for (int i = 0; i < 1030; i++)
            send_request(ssg_pkg::REQ_DRAW, 16'($urandom), 16'($urandom), 4'($urandom));

        // Hold off until every predicted sample has come back
        in_valid <= 1'b0;
        while (pending_samples != 0)
            @(negedge clk);

        // Random: mostly seed followed by a burst of draws, some stray seeds
        n_items = 0;
        while (n_items < 800)
        begin
            seed_random();
            burst = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3)
                                              : $urandom_range(4, 40);
            for (int i = 0; i < burst; i++)
                send_request(ssg_pkg::REQ_DRAW, 16'($urandom), 16'($urandom),
                             4'($urandom));
            n_items += burst + 1;
        end
        in_valid <= 1'b0;

        while (pending_samples != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        $display("Covered %0d seeds and %0d draw results, %0d of them set-full.",
                 seeds_sent, draws_seen, full_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
